// ===== hdl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and codes for the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  typedef enum logic [1:0] {
    MODE_ENCODE = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  // Input word: one encode, load or flush request.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } in_t;

  // Output word: one packed word.
  typedef struct packed {
    logic [31:0] packed_word;
    logic [5:0]  bits_valid;
    logic        is_final;
  } out_t;

  // Control of the pack stage, which waits on the code table read.
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic       sym_ok;
  } stage_t;

endpackage

`default_nettype wire

// ===== hdl/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/hcbp_pack.sv =====
// ----------------------------------------------------------------------------
// hcbp_pack
// Pack stage: merges the looked-up code into the accumulating word, spills
// into the next word on overflow and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_pack #(
  parameter int WORD_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  hcbp_pkg::stage_t                          stage_i,
  input  logic [WORD_BITS+$clog2(WORD_BITS+1)-1:0]  entry_i,
  output logic                                      take_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output hcbp_pkg::out_t                            out_data_o
);
  import hcbp_pkg::*;

  localparam int LenW = $clog2(WORD_BITS + 1);
  localparam int OffW = $clog2(WORD_BITS);
  localparam int SumW = LenW + 1;

  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [OffW-1:0]      off_q, off_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q;

  logic [WORD_BITS-1:0] code;
  logic [LenW-1:0]      len;
  logic [SumW-1:0]      sum;
  logic [WORD_BITS-1:0] merged;
  logic [LenW-1:0]      spill_shift;
  logic                 emit;
  logic [WORD_BITS-1:0] emit_word;
  logic [5:0]           emit_bits;
  logic                 emit_final;

  assign code        = entry_i[WORD_BITS+LenW-1:LenW];
  assign len         = entry_i[LenW-1:0];
  assign sum         = SumW'(off_q) + SumW'(len);
  assign merged      = acc_q | (code >> off_q);
  assign spill_shift = LenW'(WORD_BITS) - LenW'(off_q);

  // Advance whenever the output register is free or being emptied.
  assign take_o = stage_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    acc_d      = acc_q;
    off_d      = off_q;
    emit       = 1'b0;
    emit_word  = merged;
    emit_bits  = 6'(WORD_BITS);
    emit_final = 1'b0;
    if (take_o) begin
      case (stage_i.mode)
        MODE_ENCODE: begin
          if (stage_i.sym_ok) begin
            if (sum < SumW'(WORD_BITS)) begin
              acc_d = merged;
              off_d = OffW'(sum);
            end else begin
              emit  = 1'b1;
              // carry the bits that did not fit into the next word
              acc_d = (off_q == '0) ? '0 : (code << spill_shift);
              off_d = OffW'(sum - SumW'(WORD_BITS));
            end
          end
        end
        MODE_FLUSH: begin
          acc_d      = '0;
          off_d      = '0;
          emit       = (off_q != '0);
          emit_word  = acc_q;
          emit_bits  = 6'(off_q);
          emit_final = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = take_o ? emit : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      out_q.packed_word <= 32'(emit_word);
      out_q.bits_valid  <= emit_bits;
      out_q.is_final    <= emit_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder that packs table codes MSB first into output words.
// ----------------------------------------------------------------------------
// The block takes one word per cycle unless the output stalls. A load writes
// its table entry into the code RAM on acceptance, so an encode of that symbol
// may follow in the very next cycle. An encode reads the RAM on acceptance and
// is packed from the registered read data once the output register is free or
// being emptied; its output word, if the word filled, is then written into the
// output register, from which it can be taken. The sustained rate is one item
// per cycle unless the output stalls, set by the accumulator loop (one add and
// compare on the fill offset) and the single RAM read port. The code table is
// not cleared at reset: encode only symbols that have been loaded.
`default_nettype none

module huffman_code_bit_packer #(
  parameter int WORD_BITS = 32,
  parameter int SYMBOLS   = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hcbp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hcbp_pkg::out_t out_data_o
);
  import hcbp_pkg::*;

  localparam int LenW   = $clog2(WORD_BITS + 1);
  localparam int AddrW  = $clog2(SYMBOLS);
  localparam int EntryW = WORD_BITS + LenW;
  localparam int Cap    = (WORD_BITS < 32) ? WORD_BITS : 32;

  logic                 in_accept;
  logic                 sym_ok;
  logic [AddrW-1:0]     addr;
  logic [LenW-1:0]      len_sat;
  logic [WORD_BITS-1:0] code_aligned;
  logic [WORD_BITS-1:0] top_mask;
  logic [EntryW-1:0]    wdata;
  logic [EntryW-1:0]    rdata;
  logic                 we;
  logic                 re;
  logic                 take;
  stage_t               stage_q, stage_d;

  assign in_accept = in_valid_i && in_ready_o;
  assign in_ready_o = !stage_q.valid || take;
  assign sym_ok = {1'b0, in_data_i.symbol} < 9'(SYMBOLS);
  assign addr = in_data_i.symbol[AddrW-1:0];

  always_comb begin
    if (32'(in_data_i.code_length) > Cap) begin
      len_sat = LenW'(Cap);
    end else begin
      len_sat = LenW'(in_data_i.code_length);
    end
  end

  // place the 32-bit code at the top of the word
  if (WORD_BITS >= 32) begin : g_wide
    assign code_aligned = WORD_BITS'(in_data_i.code_bits) << (WORD_BITS - 32);
  end else begin : g_narrow
    assign code_aligned = in_data_i.code_bits[31 -: WORD_BITS];
  end

  // drop stray bits below the code length
  assign top_mask = ~({WORD_BITS{1'b1}} >> len_sat);
  assign wdata    = {code_aligned & top_mask, len_sat};

  assign we = in_accept && (in_data_i.mode == MODE_LOAD) && sym_ok;
  assign re = in_accept && (in_data_i.mode == MODE_ENCODE) && sym_ok;

  hcbp_ram #(
    .WIDTH(EntryW),
    .DEPTH(SYMBOLS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_comb begin
    stage_d = stage_q;
    if (in_accept) begin
      stage_d.valid  = 1'b1;
      stage_d.mode   = in_data_i.mode;
      stage_d.sym_ok = sym_ok;
    end else if (take) begin
      stage_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  hcbp_pack #(
    .WORD_BITS(WORD_BITS)
  ) u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage_q),
    .entry_i    (rdata),
    .take_o     (take),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the Huffman code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_checker #(
  parameter int WORD_BITS = 32,
  parameter int SYMBOLS   = 256
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input hcbp_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hcbp_pkg::out_t out_data_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // input backs up only behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output");

  // a full word always reports the whole word as valid
  a_full_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_final |-> out_data_o.bits_valid == 6'(WORD_BITS))
    else $error("full word with wrong bit count");

  // a fresh output word traces back to an accepted input through the stage register
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output word without a matching input");

endmodule

bind huffman_code_bit_packer hcbp_checker #(
  .WORD_BITS(WORD_BITS),
  .SYMBOLS  (SYMBOLS)
) u_checker (.*);

`default_nettype wire
